// ----- src/ohlctr_pkg.sv -----
package ohlctr_pkg;

  // field widths
  localparam int unsigned PriceW    = 31;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned PeriodW   = 17;
  localparam int unsigned LookbackW = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 17;

  // default history depth of the bar chain
  localparam int unsigned HistDepthDef = 64;

  localparam logic [PriceW-1:0]    PriceMax    = '1;
  localparam logic [PeriodW-1:0]   PeriodRst   = 17'd1800;
  localparam logic [LookbackW-1:0] LookbackRst = 7'd20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLookback = 1'b1;

  // running window extremes handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [PriceW-1:0] hi;
    logic [PriceW-1:0] lo;
  } scan_t;

  // one result item
  typedef struct packed {
    logic              bar_closed;
    logic [PriceW-1:0] bar_open;
    logic [PriceW-1:0] bar_high;
    logic [PriceW-1:0] bar_low;
    logic [PriceW-1:0] bar_close;
    logic [TimeW-1:0]  bar_begin_time;
    logic [TimeW-1:0]  bar_end_time;
    logic [PriceW-1:0] true_range;
    logic              true_range_valid;
    logic [PriceW-1:0] window_high;
    logic [PriceW-1:0] window_low;
  } res_t;

  // true range: high >= low always, so only the position of the previous close matters
  function automatic logic [PriceW-1:0] true_range_of(
    input logic [PriceW-1:0] hi,
    input logic [PriceW-1:0] lo,
    input logic [PriceW-1:0] pc
  );
    logic [PriceW-1:0] tr;
    if (pc > hi) begin
      tr = pc - lo;
    end else if (pc < lo) begin
      tr = hi - pc;
    end else begin
      tr = hi - lo;
    end
    return tr;
  endfunction

endpackage

// ----- src/ohlc_bar_true_range_aggregator_core.sv -----
// OHLC bar builder with true range and lookback window extremes.
//
// Input channel (in_valid_i / in_ready_o) carries price ticks with a time in
// seconds; every transfer yields exactly one result on the output channel
// (out_valid_o / out_ready_i). A tick that does not close the bar gives a
// result with bar_closed_o low and all other fields zero.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0: bar period in seconds, 1: lookback in bars); write only while idle.
// A tick that keeps the bar open pushes its result straight into the output
// buffer; the block takes one such tick per cycle while the buffer has space.
// A closing tick walks a token through the chain of HistoryDepth history
// cells to gather window high and low; its result is pushed when the token
// leaves the last cell, and input is held off until then.
// Results wait in a two-entry output buffer, so a stalled receiver blocks
// the input only once both entries are full.
// Reset clears the bar state, the bar count and the buffer; registers go to
// 1800 seconds and 20 bars. History cells hold garbage until written and
// are only read once written.
module ohlc_bar_true_range_aggregator_core #(
  parameter int unsigned HistoryDepth = ohlctr_pkg::HistDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ohlctr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ohlctr_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ohlctr_pkg::PriceW-1:0]      price_i,
  input  logic [ohlctr_pkg::TimeW-1:0]       tick_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               bar_closed_o,
  output logic [ohlctr_pkg::PriceW-1:0]      bar_open_o,
  output logic [ohlctr_pkg::PriceW-1:0]      bar_high_o,
  output logic [ohlctr_pkg::PriceW-1:0]      bar_low_o,
  output logic [ohlctr_pkg::PriceW-1:0]      bar_close_o,
  output logic [ohlctr_pkg::TimeW-1:0]       bar_begin_time_o,
  output logic [ohlctr_pkg::TimeW-1:0]       bar_end_time_o,
  output logic [ohlctr_pkg::PriceW-1:0]      true_range_o,
  output logic                               true_range_valid_o,
  output logic [ohlctr_pkg::PriceW-1:0]      window_high_o,
  output logic [ohlctr_pkg::PriceW-1:0]      window_low_o
);

  localparam int unsigned CntW = $clog2(HistoryDepth + 1);
  localparam int unsigned CmpW = (CntW > ohlctr_pkg::LookbackW) ? CntW : ohlctr_pkg::LookbackW;
  localparam int unsigned PW   = ohlctr_pkg::PriceW;
  localparam int unsigned TW   = ohlctr_pkg::TimeW;

  // configuration
  logic [ohlctr_pkg::PeriodW-1:0]   period_q;
  logic [ohlctr_pkg::LookbackW-1:0] lookback_q;

  // control state
  logic            bar_active_q;
  logic [CntW-1:0] bars_stored_q;
  logic            busy_q;
  logic            launch_q;
  logic [CntW-1:0] span_q;

  // bar payload
  logic [PW-1:0] cur_open_q, cur_high_q, cur_low_q, prev_close_q;
  logic [TW-1:0] cur_begin_q;
  ohlctr_pkg::res_t closed_q;

  // per-tick logic
  logic          in_xfer;
  logic [PW-1:0] open_sel, hi_sel, lo_sel, hi_new, lo_new;
  logic [TW-1:0] begin_sel, time_diff;
  logic          closes;
  logic [CntW-1:0] stored_inc;
  logic [ohlctr_pkg::LookbackW-1:0] lb_eff;
  logic [CmpW-1:0] lb_ext, stored_ext;
  logic [CntW-1:0] span_d;

  // chain
  logic [PW-1:0]     sh_hi [HistoryDepth];
  logic [PW-1:0]     sh_lo [HistoryDepth];
  logic [PW-1:0]     st_hi [HistoryDepth];
  logic [PW-1:0]     st_lo [HistoryDepth];
  ohlctr_pkg::scan_t tok   [HistoryDepth+1];
  logic              shift;
  logic              scan_done;

  // output buffer
  logic             fifo_push, fifo_space;
  ohlctr_pkg::res_t fifo_in, fifo_out;

  assign in_ready_o = !busy_q && fifo_space;
  assign in_xfer    = in_valid_i && in_ready_o;

  // bar update for the incoming tick
  always_comb begin
    open_sel  = bar_active_q ? cur_open_q  : price_i;
    hi_sel    = bar_active_q ? cur_high_q  : price_i;
    lo_sel    = bar_active_q ? cur_low_q   : price_i;
    begin_sel = bar_active_q ? cur_begin_q : tick_time_i;
    hi_new    = (price_i > hi_sel) ? price_i : hi_sel;
    lo_new    = (price_i < lo_sel) ? price_i : lo_sel;
    time_diff = tick_time_i - begin_sel;
    closes    = (tick_time_i > begin_sel) && (time_diff > TW'(period_q));
  end

  // bar count after storing this bar, and the window span it gives
  always_comb begin
    stored_inc = (bars_stored_q == CntW'(HistoryDepth)) ? bars_stored_q
                                                        : bars_stored_q + 1'b1;
    lb_eff     = (lookback_q == '0) ? ohlctr_pkg::LookbackW'(1) : lookback_q;
    lb_ext     = CmpW'(lb_eff);
    stored_ext = CmpW'(stored_inc);
    span_d     = (lb_ext > stored_ext) ? stored_inc : CntW'(lb_ext);
  end

  assign shift = in_xfer && closes;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= ohlctr_pkg::PeriodRst;
      lookback_q <= ohlctr_pkg::LookbackRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ohlctr_pkg::CfgPeriod:   period_q   <= cfg_wdata_i;
        ohlctr_pkg::CfgLookback: lookback_q <= cfg_wdata_i[ohlctr_pkg::LookbackW-1:0];
        default:                 period_q   <= period_q;
      endcase
    end
  end

  // control: bar open flag, bar count, window scan sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_active_q  <= 1'b0;
      bars_stored_q <= '0;
      busy_q        <= 1'b0;
      launch_q      <= 1'b0;
      span_q        <= '0;
    end else begin
      launch_q <= 1'b0;
      if (in_xfer) begin
        bar_active_q <= !closes;
        if (closes) begin
          bars_stored_q <= stored_inc;
          busy_q        <= 1'b1;
          launch_q      <= 1'b1;
          span_q        <= span_d;
        end
      end else if (scan_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // bar payload and the closed bar waiting for its window
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_open_q  <= open_sel;
      cur_high_q  <= hi_new;
      cur_low_q   <= lo_new;
      cur_begin_q <= begin_sel;
    end
    if (shift) begin
      prev_close_q              <= price_i;
      closed_q.bar_closed       <= 1'b1;
      closed_q.bar_open         <= open_sel;
      closed_q.bar_high         <= hi_new;
      closed_q.bar_low          <= lo_new;
      closed_q.bar_close        <= price_i;
      closed_q.bar_begin_time   <= begin_sel;
      closed_q.bar_end_time     <= tick_time_i;
      closed_q.true_range_valid <= bars_stored_q != '0;
      closed_q.true_range       <= (bars_stored_q != '0)
          ? ohlctr_pkg::true_range_of(hi_new, lo_new, prev_close_q) : '0;
      closed_q.window_high      <= '0;
      closed_q.window_low       <= '0;
    end
  end

  // scan token enters the newest cell
  assign tok[0] = '{vld: launch_q, hi: '0, lo: ohlctr_pkg::PriceMax};

  // history chain, newest bar in cell zero
  for (genvar k = 0; k < HistoryDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign sh_hi[k] = hi_new;
      assign sh_lo[k] = lo_new;
    end else begin : g_body
      assign sh_hi[k] = st_hi[k-1];
      assign sh_lo[k] = st_lo[k-1];
    end

    ohlctr_hist_cell #(
      .Idx          (k),
      .HistoryDepth (HistoryDepth)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .hi_i    (sh_hi[k]),
      .lo_i    (sh_lo[k]),
      .hi_o    (st_hi[k]),
      .lo_o    (st_lo[k]),
      .span_i  (span_q),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

  assign scan_done = tok[HistoryDepth].vld;

  // result into the output buffer
  always_comb begin
    fifo_push = (in_xfer && !closes) || scan_done;
    fifo_in   = '0;
    if (scan_done) begin
      fifo_in             = closed_q;
      fifo_in.window_high = tok[HistoryDepth].hi;
      fifo_in.window_low  = tok[HistoryDepth].lo;
    end
  end

  ohlctr_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_in),
    .space_o     (fifo_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (fifo_out)
  );

  assign bar_closed_o       = fifo_out.bar_closed;
  assign bar_open_o         = fifo_out.bar_open;
  assign bar_high_o         = fifo_out.bar_high;
  assign bar_low_o          = fifo_out.bar_low;
  assign bar_close_o        = fifo_out.bar_close;
  assign bar_begin_time_o   = fifo_out.bar_begin_time;
  assign bar_end_time_o     = fifo_out.bar_end_time;
  assign true_range_o       = fifo_out.true_range;
  assign true_range_valid_o = fifo_out.true_range_valid;
  assign window_high_o      = fifo_out.window_high;
  assign window_low_o       = fifo_out.window_low;

endmodule

// ----- src/ohlctr_hist_cell.sv -----
module ohlctr_hist_cell #(
  parameter int unsigned Idx          = 0,
  parameter int unsigned HistoryDepth = ohlctr_pkg::HistDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  logic [ohlctr_pkg::PriceW-1:0]       hi_i,
  input  logic [ohlctr_pkg::PriceW-1:0]       lo_i,
  output logic [ohlctr_pkg::PriceW-1:0]       hi_o,
  output logic [ohlctr_pkg::PriceW-1:0]       lo_o,
  input  logic [$clog2(HistoryDepth+1)-1:0]   span_i,
  input  ohlctr_pkg::scan_t                   tok_i,
  output ohlctr_pkg::scan_t                   tok_o
);

  localparam int unsigned CntW = $clog2(HistoryDepth + 1);

  logic [ohlctr_pkg::PriceW-1:0] hi_q, lo_q;
  logic                          vld_q;
  logic [ohlctr_pkg::PriceW-1:0] acc_hi_q, acc_lo_q;
  logic [ohlctr_pkg::PriceW-1:0] acc_hi_d, acc_lo_d;
  logic                          in_win;

  // this cell holds the bar of age Idx; it counts only inside the window
  assign in_win = CntW'(Idx) < span_i;

  always_comb begin
    acc_hi_d = tok_i.hi;
    acc_lo_d = tok_i.lo;
    if (in_win) begin
      if (hi_q > tok_i.hi) begin
        acc_hi_d = hi_q;
      end
      if (lo_q < tok_i.lo) begin
        acc_lo_d = lo_q;
      end
    end
  end

  // scan token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  // stored bar and accumulator payload
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hi_q <= hi_i;
      lo_q <= lo_i;
    end
    if (tok_i.vld) begin
      acc_hi_q <= acc_hi_d;
      acc_lo_q <= acc_lo_d;
    end
  end

  assign hi_o  = hi_q;
  assign lo_o  = lo_q;
  assign tok_o = '{vld: vld_q, hi: acc_hi_q, lo: acc_lo_q};

endmodule

// ----- src/ohlctr_res_fifo.sv -----
module ohlctr_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ohlctr_pkg::res_t   push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ohlctr_pkg::res_t   out_data_o
);

  ohlctr_pkg::res_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign space_o     = cnt_q != 2'd2;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/ohlctr_checker.sv -----
module ohlctr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            bar_closed_o,
  input logic [ohlctr_pkg::PriceW-1:0]   bar_open_o,
  input logic [ohlctr_pkg::PriceW-1:0]   bar_high_o,
  input logic [ohlctr_pkg::PriceW-1:0]   bar_low_o,
  input logic [ohlctr_pkg::PriceW-1:0]   bar_close_o,
  input logic [ohlctr_pkg::TimeW-1:0]    bar_begin_time_o,
  input logic [ohlctr_pkg::TimeW-1:0]    bar_end_time_o,
  input logic [ohlctr_pkg::PriceW-1:0]   true_range_o,
  input logic                            true_range_valid_o,
  input logic [ohlctr_pkg::PriceW-1:0]   window_high_o,
  input logic [ohlctr_pkg::PriceW-1:0]   window_low_o
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // an open bar reports nothing but zeros
  a_open_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bar_closed_o |->
      bar_open_o == '0 && bar_high_o == '0 && bar_low_o == '0 && bar_close_o == '0 &&
      bar_begin_time_o == '0 && bar_end_time_o == '0 && true_range_o == '0 &&
      !true_range_valid_o && window_high_o == '0 && window_low_o == '0)
    else $error("non-closing result carries data");

  // window includes the bar just closed, and the bar spans its prices
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bar_closed_o |->
      bar_low_o <= bar_high_o && window_high_o >= bar_high_o &&
      window_low_o <= bar_low_o && bar_open_o <= bar_high_o &&
      bar_open_o >= bar_low_o && bar_close_o <= bar_high_o && bar_close_o >= bar_low_o)
    else $error("closed bar or window extremes inconsistent");

  // a closed bar ends after it begins and true range covers the bar range (zero when not valid)
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bar_closed_o |->
      bar_end_time_o > bar_begin_time_o &&
      (true_range_valid_o ? (true_range_o >= bar_high_o - bar_low_o) : (true_range_o == '0)))
    else $error("closed bar time or true range inconsistent");

endmodule

bind ohlc_bar_true_range_aggregator_core ohlctr_checker u_ohlctr_checker (.*);

// ----- tb/tb_ohlc_bar_true_range_aggregator_core.sv -----
`timescale 1ns / 1ps

module tb_ohlc_bar_true_range_aggregator_core;

  localparam int unsigned PriceW    = ohlctr_pkg::PriceW;
  localparam int unsigned TimeW     = ohlctr_pkg::TimeW;
  localparam int unsigned PeriodW   = ohlctr_pkg::PeriodW;
  localparam int unsigned LookbackW = ohlctr_pkg::LookbackW;
  localparam int unsigned CfgIdxW   = ohlctr_pkg::CfgIdxW;
  localparam int unsigned CfgDataW  = ohlctr_pkg::CfgDataW;

  localparam logic [PriceW-1:0]    PriceMax    = ohlctr_pkg::PriceMax;
  localparam logic [PeriodW-1:0]   PeriodRst   = ohlctr_pkg::PeriodRst;
  localparam logic [LookbackW-1:0] LookbackRst = ohlctr_pkg::LookbackRst;
  localparam logic [CfgIdxW-1:0]   CfgPeriod   = ohlctr_pkg::CfgPeriod;
  localparam logic [CfgIdxW-1:0]   CfgLookback = ohlctr_pkg::CfgLookback;

  typedef ohlctr_pkg::res_t res_t;

  localparam int unsigned RingDepth  = ohlctr_pkg::HistDepthDef;
  localparam int unsigned StallLimit = 4000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = CfgPeriod;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [PriceW-1:0]    price_i     = '0;
  logic [TimeW-1:0]     tick_time_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 bar_closed_o;
  logic [PriceW-1:0]    bar_open_o;
  logic [PriceW-1:0]    bar_high_o;
  logic [PriceW-1:0]    bar_low_o;
  logic [PriceW-1:0]    bar_close_o;
  logic [TimeW-1:0]     bar_begin_time_o;
  logic [TimeW-1:0]     bar_end_time_o;
  logic [PriceW-1:0]    true_range_o;
  logic                 true_range_valid_o;
  logic [PriceW-1:0]    window_high_o;
  logic [PriceW-1:0]    window_low_o;

  ohlc_bar_true_range_aggregator_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .price_i            (price_i),
    .tick_time_i        (tick_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .bar_closed_o       (bar_closed_o),
    .bar_open_o         (bar_open_o),
    .bar_high_o         (bar_high_o),
    .bar_low_o          (bar_low_o),
    .bar_close_o        (bar_close_o),
    .bar_begin_time_o   (bar_begin_time_o),
    .bar_end_time_o     (bar_end_time_o),
    .true_range_o       (true_range_o),
    .true_range_valid_o (true_range_valid_o),
    .window_high_o      (window_high_o),
    .window_low_o       (window_low_o)
  );

  // bar builder state mirrored by the testbench
  logic [PeriodW-1:0]   cfg_period   = PeriodRst;
  logic [LookbackW-1:0] cfg_lookback = LookbackRst;
  logic                 bar_live     = 1'b0;
  logic [PriceW-1:0]    live_open    = '0;
  logic [PriceW-1:0]    live_high    = '0;
  logic [PriceW-1:0]    live_low     = '0;
  logic [TimeW-1:0]     live_begin   = '0;
  logic [PriceW-1:0]    last_close   = '0;
  int unsigned          bars_kept    = 0;
  int unsigned          ring_wr      = 0;
  logic [PriceW-1:0]    ring_high [RingDepth];
  logic [PriceW-1:0]    ring_low  [RingDepth];

  res_t bar_results_q [$];

  // tick feed state for the random part
  logic [TimeW-1:0] feed_time  = '0;
  longint           feed_level = 0;

  int src_gap_max    = 13;
  int snk_gap_max    = 13;
  int snk_hold       = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // next bar result for one accepted tick
  task automatic predict_bar_result(input logic [PriceW-1:0] p, input logic [TimeW-1:0] t);
    res_t              r;
    int unsigned       span;
    int unsigned       slot;
    logic [PriceW-1:0] hi_w;
    logic [PriceW-1:0] lo_w;
    longint            spread;
    longint            up;
    longint            dn;
    r = '0;
    if (!bar_live) begin
      bar_live   = 1'b1;
      live_open  = p;
      live_high  = p;
      live_low   = p;
      live_begin = t;
    end
    if (p < live_low) live_low = p;
    if (p > live_high) live_high = p;
    if (t > live_begin && (t - live_begin) > TimeW'(cfg_period)) begin
      r.bar_closed     = 1'b1;
      r.bar_open       = live_open;
      r.bar_high       = live_high;
      r.bar_low        = live_low;
      r.bar_close      = p;
      r.bar_begin_time = live_begin;
      r.bar_end_time   = t;
      if (bars_kept > 0) begin
        spread = longint'(live_high) - longint'(live_low);
        up     = longint'(live_high) - longint'(last_close);
        dn     = longint'(last_close) - longint'(live_low);
        if (up > spread) spread = up;
        if (dn > spread) spread = dn;
        if (spread < 0) spread = 0;
        r.true_range       = spread[PriceW-1:0];
        r.true_range_valid = 1'b1;
      end
      // push into the history ring
      ring_high[ring_wr] = live_high;
      ring_low[ring_wr]  = live_low;
      ring_wr = (ring_wr + 1 >= RingDepth) ? 0 : ring_wr + 1;
      if (bars_kept < RingDepth) bars_kept++;
      // window over the newest bars
      span = cfg_lookback;
      if (span < 1) span = 1;
      if (span > bars_kept) span = bars_kept;
      hi_w = '0;
      lo_w = PriceMax;
      for (int unsigned k = 0; k < span; k++) begin
        slot = (ring_wr + RingDepth - 1 - k) % RingDepth;
        if (ring_high[slot] > hi_w) hi_w = ring_high[slot];
        if (ring_low[slot] < lo_w) lo_w = ring_low[slot];
      end
      r.window_high = hi_w;
      r.window_low  = lo_w;
      last_close = p;
      bar_live   = 1'b0;
    end
    bar_results_q = {bar_results_q, r};
  endtask

  // one tick transfer on the input channel
  task automatic send_tick(input logic [PriceW-1:0] p, input logic [TimeW-1:0] t);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    price_i     <= p;
    tick_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_bar_result(p, t);
  endtask

  // stop sending and wait for every pending result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bar_results_q.size() != 0) @(posedge clk_i);
  endtask

  // both registers, written while the block is idle
  task automatic set_config(input logic [PeriodW-1:0] period,
                            input logic [LookbackW-1:0] lookback);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgPeriod;
    cfg_wdata_i <= CfgDataW'(period);
    @(posedge clk_i);
    cfg_idx_i   <= CfgLookback;
    cfg_wdata_i <= CfgDataW'(lookback);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_period   = period;
    cfg_lookback = lookback;
    @(posedge clk_i);
  endtask

  // mostly forward-moving ticks with a price walk, some late and some wild ticks
  task automatic run_random_ticks(input int n);
    int unsigned       kind;
    int unsigned       reach;
    logic [TimeW-1:0]  t;
    logic [PriceW-1:0] p;
    reach = (cfg_period == 0) ? 1 : cfg_period / 2 + 1;
    for (int i = 0; i < n; i++) begin
      kind = bar_live ? $urandom_range(99, 0) : 0;
      if (kind < 85) begin
        if ($urandom_range(19, 0) == 0) feed_time += TimeW'(reach * 3);
        else feed_time += TimeW'($urandom_range(reach, 0));
        feed_level += longint'($urandom_range(1024, 0)) - 512;
        if (feed_level < 0) feed_level = 0;
        if (feed_level > longint'(PriceMax)) feed_level = longint'(PriceMax);
        t = feed_time;
        p = feed_level[PriceW-1:0];
      end else if (kind < 93) begin
        // tick stamped before the bar began
        t = live_begin - TimeW'($urandom_range(60, 1));
        p = feed_level[PriceW-1:0] ^ PriceW'($urandom_range(4095, 0));
      end else begin
        t = $urandom();
        p = PriceW'($urandom());
      end
      send_tick(p, t);
    end
  endtask

  // first bar at the reset register values, period boundary hit exactly
  task automatic test_reset_registers();
    send_tick(PriceW'(100), 32'd0);
    send_tick(PriceMax, 32'd1800);
    send_tick('0, 32'd1801);
  endtask

  // zero period, lookback limits, late ticks, time wrap and true range cases
  task automatic test_corner_ticks();
    set_config(17'd0, 7'd0);
    send_tick(PriceW'(5000), 32'hFFFF_FFF0);
    send_tick(PriceW'(7000), 32'hFFFF_FF00);
    send_tick(PriceW'(4000), 32'hFFFF_FFF0);
    send_tick(PriceW'(6000), 32'hFFFF_FFFF);
    send_tick(PriceMax, 32'd0);
    send_tick(PriceMax, 32'd1);
    set_config(17'h1FFFF, 7'h7F);
    send_tick(PriceW'(123), 32'd10);
    send_tick(PriceW'(1), 32'd131081);
    send_tick(PriceW'(2), 32'd131082);
    // previous close below the bar
    send_tick(PriceW'(50), 32'd200000);
    send_tick(PriceW'(60), 32'd331072);
    // previous close above the bar
    send_tick(PriceW'(10), 32'd400000);
    send_tick(PriceW'(20), 32'd600000);
  endtask

  // random ticks over a sweep of register settings
  task automatic test_config_sweep();
    logic [PeriodW-1:0]   per_tab [8];
    logic [LookbackW-1:0] look_tab [8];
    per_tab  = '{17'd0, 17'd1, 17'd86400, 17'h1FFFF, 17'd300, 17'd1800, 17'd40, 17'd7};
    look_tab = '{7'd1, 7'd64, 7'd0, 7'h7F, 7'd65, 7'd20, 7'd2, 7'd33};
    per_tab[4]  = PeriodW'($urandom_range(600, 2));
    look_tab[6] = LookbackW'($urandom_range(63, 2));
    feed_time  = $urandom_range(32'hF000_0000, 0);
    feed_level = longint'(PriceW'($urandom()));
    for (int ph = 0; ph < 8; ph++) begin
      set_config(per_tab[ph], look_tab[ph]);
      src_gap_max = (ph == 3) ? 0 : 13;
      snk_gap_max = (ph == 5) ? 0 : 13;
      run_random_ticks(80);
    end
    src_gap_max = 13;
    snk_gap_max = 13;
  endtask

  // receiver stalls long while ticks keep coming, so the input backs up
  task automatic test_receiver_backpressure();
    set_config(17'd20, 7'd8);
    src_gap_max = 0;
    snk_hold    = 300;
    run_random_ticks(40);
    src_gap_max = 13;
  endtask

  // sender goes quiet until everything is out, then resumes
  task automatic test_sender_pause();
    run_random_ticks(40);
    wait_drained();
    run_random_ticks(40);
  endtask

  // no idle cycles on either side
  task automatic test_back_to_back();
    set_config(17'd5, 7'd64);
    src_gap_max = 0;
    snk_gap_max = 0;
    run_random_ticks(60);
    wait_drained();
    src_gap_max = 13;
    snk_gap_max = 13;
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_corner_ticks();
    test_config_sweep();
    test_receiver_backpressure();
    test_sender_pause();
    test_back_to_back();
    wait_drained();
    repeat (RingDepth + 8) @(posedge clk_i);
    if (mismatch_count == 0 && bar_results_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random ready gaps, plus a long hold when requested
  initial begin : result_sink
    int pause;
    @(posedge rst_ni);
    forever begin
      if (snk_hold > 0) begin
        pause    = snk_hold;
        snk_hold = 0;
      end else begin
        pause = $urandom_range(snk_gap_max, 0);
      end
      if (pause > 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // compare each output transfer against the oldest pending bar result
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bar_results_q.size() == 0) begin
        $display("%0t: result transfer with nothing pending", $time);
        mismatch_count++;
      end else begin
        want = bar_results_q.pop_front();
        cmp_field("bar_closed", 32'(want.bar_closed), 32'(bar_closed_o));
        cmp_field("bar_open", 32'(want.bar_open), 32'(bar_open_o));
        cmp_field("bar_high", 32'(want.bar_high), 32'(bar_high_o));
        cmp_field("bar_low", 32'(want.bar_low), 32'(bar_low_o));
        cmp_field("bar_close", 32'(want.bar_close), 32'(bar_close_o));
        cmp_field("bar_begin_time", want.bar_begin_time, bar_begin_time_o);
        cmp_field("bar_end_time", want.bar_end_time, bar_end_time_o);
        cmp_field("true_range", 32'(want.true_range), 32'(true_range_o));
        cmp_field("true_range_valid", 32'(want.true_range_valid), 32'(true_range_valid_o));
        cmp_field("window_high", 32'(want.window_high), 32'(window_high_o));
        cmp_field("window_low", 32'(want.window_low), 32'(window_low_o));
      end
    end
  end

  // watchdog: no transfer for too long while work is outstanding
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && bar_results_q.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
